// ----- rtl/core/priority_clock_frame_replacer_core_defines.svh -----
// Assertion macros used by the frame replacer control FSM.
`ifndef PRIORITY_CLOCK_FRAME_REPLACER_CORE_DEFINES_SVH
`define PRIORITY_CLOCK_FRAME_REPLACER_CORE_DEFINES_SVH

`ifndef SYNTH
`define PCFR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("pcfr check failed");
`define PCFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   `PCFR_ASSERT(label, clk, rst, (ante) |=> (cons))
`else
`define PCFR_ASSERT(label, clk, rst, prop)
`define PCFR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/core/pcfr_pkg.sv -----
package pcfr_pkg;

   localparam int FRAMES     = 64;
   localparam int LEVEL_BITS = 3;
   localparam int IDX_W      = $clog2(FRAMES);
   localparam int STEP_W     = $clog2(FRAMES * 2);
   localparam int PAGE_W     = 44;
   localparam int VPAGE_W    = 27;
   localparam int OWNER_W    = 15;
   localparam int SLOT_W     = 6;

   localparam logic [OWNER_W-1:0] PROT_ID_A = OWNER_W'(1);
   localparam logic [OWNER_W-1:0] PROT_ID_B = OWNER_W'(2);

   typedef enum logic [1:0] {
      KIND_ALLOC = 2'd0,
      KIND_FREE  = 2'd1,
      KIND_MARK  = 2'd2,
      KIND_LEVEL = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_MISS      = 2'd1,
      ST_NO_VICTIM = 2'd2,
      ST_NO_EVICT  = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [PAGE_W-1:0]  page_number;
      logic               page_offered;
      logic [VPAGE_W-1:0] virt_page;
      logic [OWNER_W-1:0] owner_id;
      logic [2:0]         owner_level;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  frame_slot;
      logic [PAGE_W-1:0]  result_page;
      logic               evicted;
      logic [OWNER_W-1:0] victim_owner;
      logic [VPAGE_W-1:0] victim_virt_page;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic [OWNER_W-1:0]    owner;
      logic [LEVEL_BITS-1:0] level;
      logic [PAGE_W-1:0]     phys;
      logic [VPAGE_W-1:0]    virt;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [3:0] {
      OUT_NONE,
      OUT_FILL_FREE,
      OUT_EVICT,
      OUT_NO_VICTIM,
      OUT_NO_EVICT,
      OUT_FREE,
      OUT_MARK,
      OUT_MISS,
      OUT_LEVEL
   } outcome_type;

   typedef struct packed {
      logic        load;
      logic        scan_rd;
      logic        scan_ev;
      logic        clk_start;
      logic        clk_rd;
      logic        clk_ev;
      logic        pass2;
      logic        finish;
      outcome_type outcome;
   } cmd_type;

   typedef struct packed {
      logic     scan_last;
      logic     step_last;
      logic     victim_hit;
      logic     victim_found;
      logic     free_found;
      logic     top_found;
      logic     match_found;
      logic     offered;
      kind_type kind;
   } stat_type;

   function automatic logic is_protected(logic [OWNER_W-1:0] id);
      return (id == PROT_ID_A) || (id == PROT_ID_B);
   endfunction

endpackage

// ----- rtl/core/pcfr_ram.sv -----
module pcfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/pcfr_dpath.sv -----
module pcfr_dpath (
   input  logic              clock,
   input  logic              reset,
   input  pcfr_pkg::req_type req_data,
   input  pcfr_pkg::cmd_type cmd,
   output pcfr_pkg::stat_type stat,
   output logic              rsp_strobe,
   output pcfr_pkg::rsp_type rsp_data
);
   import pcfr_pkg::*;

   req_type               req_ff;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [IDX_W-1:0]      hand_ff, hand_in;
   logic [FRAMES-1:0]     used_ff, used_in;
   logic [FRAMES-1:0]     ref_ff, ref_in;
   logic [FRAMES-1:0]     acc_ff, acc_in;
   logic                  free_found_ff, free_found_in;
   logic [IDX_W-1:0]      free_slot_ff, free_slot_in;
   logic                  top_found_ff, top_found_in;
   logic [LEVEL_BITS-1:0] top_ff, top_in;
   logic                  match_found_ff, match_found_in;
   logic [IDX_W-1:0]      match_slot_ff, match_slot_in;
   logic                  victim_found_ff, victim_found_in;
   logic [IDX_W-1:0]      victim_slot_ff, victim_slot_in;
   entry_type             victim_ff, victim_in;
   logic                  rsp_strobe_ff;
   rsp_type               rsp_ff, rsp_in;

   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   entry_type             wr_entry;
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic [ENTRY_W-1:0]    rd_raw;
   entry_type             rd_entry;
   logic [LEVEL_BITS-1:0] req_lvl;
   logic                  cand;
   logic                  victim_hit;

   assign rd_entry = entry_type'(rd_raw);
   assign req_lvl  = req_ff.owner_level[LEVEL_BITS-1:0];
   assign rd_en    = cmd.scan_rd | cmd.clk_rd;
   assign rd_addr  = cmd.clk_rd ? hand_ff : idx_ff;

   pcfr_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (FRAMES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (ENTRY_W'(wr_entry)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign cand = used_ff[hand_ff] && !is_protected(rd_entry.owner) &&
                 (cmd.pass2 || rd_entry.level == top_ff);
   assign victim_hit = cmd.clk_ev && cand && !ref_ff[hand_ff] && !acc_ff[hand_ff];

   always_comb begin
      idx_in          = idx_ff;
      step_in         = step_ff;
      hand_in         = hand_ff;
      used_in         = used_ff;
      ref_in          = ref_ff;
      acc_in          = acc_ff;
      free_found_in   = free_found_ff;
      free_slot_in    = free_slot_ff;
      top_found_in    = top_found_ff;
      top_in          = top_ff;
      match_found_in  = match_found_ff;
      match_slot_in   = match_slot_ff;
      victim_found_in = victim_found_ff;
      victim_slot_in  = victim_slot_ff;
      victim_in       = victim_ff;
      rsp_in          = '0;
      wr_en           = 1'b0;
      wr_addr         = idx_ff;
      wr_entry        = rd_entry;

      if (cmd.load) begin
         idx_in          = '0;
         free_found_in   = 1'b0;
         top_found_in    = 1'b0;
         match_found_in  = 1'b0;
         victim_found_in = 1'b0;
      end

      if (cmd.scan_ev) begin
         if (!used_ff[idx_ff] && !free_found_ff) begin
            free_found_in = 1'b1;
            free_slot_in  = idx_ff;
         end
         if (used_ff[idx_ff] && !is_protected(rd_entry.owner) &&
             (!top_found_ff || rd_entry.level > top_ff)) begin
            top_found_in = 1'b1;
            top_in       = rd_entry.level;
         end
         if (used_ff[idx_ff] && rd_entry.phys == req_ff.page_number && !match_found_ff) begin
            match_found_in = 1'b1;
            match_slot_in  = idx_ff;
         end
         if (kind_type'(req_ff.kind) == KIND_LEVEL && used_ff[idx_ff] &&
             rd_entry.owner == req_ff.owner_id) begin
            wr_en          = 1'b1;
            wr_addr        = idx_ff;
            wr_entry       = rd_entry;
            wr_entry.level = req_lvl;
         end
         idx_in = (idx_ff == IDX_W'(FRAMES - 1)) ? '0 : idx_ff + 1'b1;
      end

      if (cmd.clk_start) begin
         step_in = '0;
      end

      if (cmd.clk_ev) begin
         hand_in = (hand_ff == IDX_W'(FRAMES - 1)) ? '0 : hand_ff + 1'b1;
         step_in = step_ff + 1'b1;
         if (cand) begin
            ref_in[hand_ff] = 1'b0;
            acc_in[hand_ff] = 1'b0;
         end
         if (victim_hit) begin
            victim_found_in = 1'b1;
            victim_slot_in  = hand_ff;
            victim_in       = rd_entry;
         end
      end

      if (cmd.finish) begin
         unique case (cmd.outcome)
            OUT_FILL_FREE: begin
               wr_en                = 1'b1;
               wr_addr              = free_slot_ff;
               wr_entry             = '{req_ff.owner_id, req_lvl,
                                        req_ff.page_number, req_ff.virt_page};
               used_in[free_slot_ff] = 1'b1;
               ref_in[free_slot_ff]  = 1'b1;
               acc_in[free_slot_ff]  = 1'b0;
               rsp_in.frame_slot    = SLOT_W'(free_slot_ff);
               rsp_in.result_page   = req_ff.page_number;
            end
            OUT_EVICT: begin
               wr_en                   = 1'b1;
               wr_addr                 = victim_slot_ff;
               wr_entry                = '{req_ff.owner_id, req_lvl,
                                           victim_ff.phys, req_ff.virt_page};
               used_in[victim_slot_ff] = 1'b1;
               ref_in[victim_slot_ff]  = 1'b1;
               acc_in[victim_slot_ff]  = 1'b0;
               rsp_in.frame_slot       = SLOT_W'(victim_slot_ff);
               rsp_in.result_page      = victim_ff.phys;
               rsp_in.evicted          = 1'b1;
               rsp_in.victim_owner     = victim_ff.owner;
               rsp_in.victim_virt_page = victim_ff.virt;
            end
            OUT_NO_VICTIM: rsp_in.status = ST_NO_VICTIM;
            OUT_NO_EVICT:  rsp_in.status = ST_NO_EVICT;
            OUT_FREE: begin
               used_in[match_slot_ff] = 1'b0;
               ref_in[match_slot_ff]  = 1'b0;
               acc_in[match_slot_ff]  = 1'b0;
               rsp_in.frame_slot      = SLOT_W'(match_slot_ff);
            end
            OUT_MARK: begin
               acc_in[match_slot_ff] = 1'b1;
               rsp_in.frame_slot     = SLOT_W'(match_slot_ff);
            end
            OUT_MISS:  rsp_in.status = ST_MISS;
            OUT_LEVEL: rsp_in.status = ST_DONE;
            default:   rsp_in.status = ST_DONE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hand_ff         <= '0;
         used_ff         <= '0;
         ref_ff          <= '0;
         acc_ff          <= '0;
         rsp_strobe_ff   <= 1'b0;
         free_found_ff   <= 1'b0;
         top_found_ff    <= 1'b0;
         match_found_ff  <= 1'b0;
         victim_found_ff <= 1'b0;
         idx_ff          <= '0;
         step_ff         <= '0;
      end else begin
         hand_ff         <= hand_in;
         used_ff         <= used_in;
         ref_ff          <= ref_in;
         acc_ff          <= acc_in;
         rsp_strobe_ff   <= cmd.finish;
         free_found_ff   <= free_found_in;
         top_found_ff    <= top_found_in;
         match_found_ff  <= match_found_in;
         victim_found_ff <= victim_found_in;
         idx_ff          <= idx_in;
         step_ff         <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      free_slot_ff   <= free_slot_in;
      top_ff         <= top_in;
      match_slot_ff  <= match_slot_in;
      victim_slot_ff <= victim_slot_in;
      victim_ff      <= victim_in;
      rsp_ff         <= rsp_in;
   end

   assign stat.scan_last    = (idx_ff == IDX_W'(FRAMES - 1));
   assign stat.step_last    = (step_ff == STEP_W'(FRAMES * 2 - 1));
   assign stat.victim_hit   = victim_hit;
   assign stat.victim_found = victim_found_ff;
   assign stat.free_found   = free_found_ff;
   assign stat.top_found    = top_found_ff;
   assign stat.match_found  = match_found_ff;
   assign stat.offered      = req_ff.page_offered;
   assign stat.kind         = kind_type'(req_ff.kind);

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ----- rtl/core/pcfr_ctrl.sv -----
`include "priority_clock_frame_replacer_core_defines.svh"

module pcfr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  pcfr_pkg::stat_type stat,
   output pcfr_pkg::cmd_type  cmd
);
   import pcfr_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_SCAN_RD = 7'b0000010,
      S_SCAN_EV = 7'b0000100,
      S_DECIDE  = 7'b0001000,
      S_CLK_RD  = 7'b0010000,
      S_CLK_EV  = 7'b0100000,
      S_FINISH  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      pass2_ff, pass2_in;
   logic      need_evict;

   assign need_evict = (stat.kind == KIND_ALLOC) && !(stat.free_found && stat.offered);

   always_comb begin
      state_in    = state_ff;
      pass2_in    = pass2_ff;
      cmd         = '0;
      cmd.outcome = OUT_NONE;
      cmd.pass2   = pass2_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            cmd.scan_rd = 1'b1;
            state_in    = S_SCAN_EV;
         end
         S_SCAN_EV: begin
            cmd.scan_ev = 1'b1;
            state_in    = stat.scan_last ? S_DECIDE : S_SCAN_RD;
         end
         S_DECIDE: begin
            if (need_evict && stat.top_found) begin
               cmd.clk_start = 1'b1;
               pass2_in      = 1'b0;
               state_in      = S_CLK_RD;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_CLK_RD: begin
            cmd.clk_rd = 1'b1;
            state_in   = S_CLK_EV;
         end
         S_CLK_EV: begin
            cmd.clk_ev = 1'b1;
            priority if (stat.victim_hit) begin
               state_in = S_FINISH;
            end else if (stat.step_last && !pass2_ff) begin
               cmd.clk_start = 1'b1;
               pass2_in      = 1'b1;
               state_in      = S_CLK_RD;
            end else if (stat.step_last) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_CLK_RD;
            end
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
            unique case (stat.kind)
               KIND_ALLOC: begin
                  priority if (!need_evict)        cmd.outcome = OUT_FILL_FREE;
                  else if (!stat.top_found)        cmd.outcome = OUT_NO_EVICT;
                  else if (stat.victim_found)      cmd.outcome = OUT_EVICT;
                  else                             cmd.outcome = OUT_NO_VICTIM;
               end
               KIND_FREE: cmd.outcome = stat.match_found ? OUT_FREE : OUT_MISS;
               KIND_MARK: cmd.outcome = stat.match_found ? OUT_MARK : OUT_MISS;
               KIND_LEVEL: cmd.outcome = OUT_LEVEL;
               default: cmd.outcome = OUT_NONE;
            endcase
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pass2_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass2_ff <= pass2_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   `PCFR_ASSERT_NEXT(a_accept_scans, clock, reset, start && !busy, state_ff == S_SCAN_RD)
   `PCFR_ASSERT_NEXT(a_finish_idles, clock, reset, cmd.finish, !busy)
   `PCFR_ASSERT_NEXT(a_hit_finishes, clock, reset, cmd.clk_ev && stat.victim_hit, state_ff == S_FINISH)
   `PCFR_ASSERT(a_one_step_cmd, clock, reset, $onehot0({cmd.load, cmd.scan_rd, cmd.scan_ev, cmd.clk_rd, cmd.clk_ev, cmd.finish}))

endmodule

// ----- rtl/core/priority_clock_frame_replacer_core.sv -----
// Frame replacer with priority-aware second-chance clock eviction.
// Request channel: drive req_data and raise start; the beat is taken on a
// clock edge where start is high and busy is low. busy stays high until the
// result has been produced; then the next beat may be taken.
// Result channel: rsp_data is valid for the single cycle rsp_strobe is high,
// one beat per request. The receiver cannot stall; it must take it then.
// Sequence: every request first sweeps the frame table frame by frame
// (registered memory read, then evaluate), then passes a decide state and
// a finish state. An allocation that must evict runs clock steps between
// those two, each a read then an evaluate, 2*FRAMES steps per pass and up
// to two passes. The single read port of the frame attribute memory sets
// this read-then-evaluate pace. rsp_strobe is high in the first cycle in
// which busy reads low again; a new beat may be taken in that cycle.
// Reset: synchronous, active high; all frames become free, the hand returns
// to frame zero and no result is pending. No memory clearing pass is needed.
module priority_clock_frame_replacer_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  pcfr_pkg::req_type req_data,
   output logic              rsp_strobe,
   output pcfr_pkg::rsp_type rsp_data
);
   import pcfr_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   pcfr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   pcfr_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
